// ===== sv/plu_pkg.sv =====
// ----------------------------------------------------------------------------
// plu_pkg
// shared types and codes of the positional list engine
// ----------------------------------------------------------------------------
package plu_pkg;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 7;
  localparam int STAT_W   = 2;
  localparam int GRP_SIZE = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_GET    = 3'd2,
    CMD_SET    = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE   = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CO_HOLD   = 2'd0,
    CO_INSERT = 2'd1,
    CO_REMOVE = 2'd2,
    CO_WRITE  = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic             rd_en;
    logic [POS_W-1:0] idx;
  } cell_ctl_t;

endpackage

// ===== sv/plu_cell.sv =====
// ----------------------------------------------------------------------------
// plu_cell
// one list entry; shifts toward its neighbors on insert and remove
// ----------------------------------------------------------------------------
module plu_cell #(
  parameter int IDX        = 0,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                  clk_i,
  input  plu_pkg::cell_ctl_t    ctl_i,
  input  logic [ITEM_WIDTH-1:0] item_i,
  input  logic [ITEM_WIDTH-1:0] left_i,
  input  logic [ITEM_WIDTH-1:0] right_i,
  output logic [ITEM_WIDTH-1:0] data_o,
  output logic [ITEM_WIDTH-1:0] rd_o
);
  import plu_pkg::*;

  localparam logic [POS_W-1:0] MyIdx = POS_W'(IDX);

  logic [ITEM_WIDTH-1:0] data_d, data_q;
  logic                  hit, above;

  assign hit   = (MyIdx == ctl_i.idx);
  assign above = (MyIdx > ctl_i.idx);

  always_comb begin
    data_d = data_q;
    case (ctl_i.op)
      CO_INSERT: begin
        if (above) begin
          data_d = left_i;
        end else if (hit) begin
          data_d = item_i;
        end
      end
      CO_REMOVE: begin
        if (above || hit) begin
          data_d = right_i;
        end
      end
      CO_WRITE: begin
        if (hit) begin
          data_d = item_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (ctl_i.rd_en && hit) ? data_q : '0;

endmodule

// ===== sv/plu_ctrl.sv =====
// ----------------------------------------------------------------------------
// plu_ctrl
// position checks, entry count and result status
// ----------------------------------------------------------------------------
module plu_ctrl #(
  parameter int DEPTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [plu_pkg::CMD_W-1:0]   command_i,
  input  logic [plu_pkg::POS_W-1:0]   position_i,
  output plu_pkg::cell_ctl_t          ctl_o,
  output logic                        done_o,
  output logic [plu_pkg::STAT_W-1:0]  status_o,
  output logic [plu_pkg::POS_W-1:0]   count_o
);
  import plu_pkg::*;

  logic             accept;
  logic             pos_nz, in_range, ins_range, full;
  logic [POS_W-1:0] idx;
  logic [POS_W-1:0] count_d, count_q;
  status_e          status_d, status_q;
  logic             done_q;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign idx       = position_i - POS_W'(1);
  assign pos_nz    = (position_i != '0);
  assign in_range  = pos_nz && (position_i <= count_q);
  assign ins_range = pos_nz && (idx <= count_q);
  assign full      = (count_q == POS_W'(DEPTH));

  always_comb begin
    ctl_o.op    = CO_HOLD;
    ctl_o.rd_en = 1'b0;
    ctl_o.idx   = idx;
    status_d    = ST_DONE;
    count_d     = count_q;
    if (accept) begin
      case (cmd_e'(command_i))
        CMD_INSERT: begin
          if (!ins_range) begin
            status_d = ST_BADPOS;
          end else if (full) begin
            status_d = ST_FULL;
          end else begin
            ctl_o.op = CO_INSERT;
            count_d  = count_q + POS_W'(1);
          end
        end
        CMD_REMOVE: begin
          if (!in_range) begin
            status_d = ST_BADPOS;
          end else begin
            ctl_o.op = CO_REMOVE;
            count_d  = count_q - POS_W'(1);
          end
        end
        CMD_GET: begin
          if (!in_range) begin
            status_d = ST_BADPOS;
          end else begin
            ctl_o.rd_en = 1'b1;
          end
        end
        CMD_SET: begin
          if (!in_range) begin
            status_d = ST_BADPOS;
          end else begin
            ctl_o.op = CO_WRITE;
          end
        end
        CMD_CLEAR: count_d = '0;
        default:   status_d = ST_DONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q   <= 1'b0;
      status_q <= ST_DONE;
      count_q  <= '0;
    end else begin
      done_q <= accept;
      if (accept) begin
        status_q <= status_d;
        count_q  <= count_d;
      end
    end
  end

  assign done_o   = done_q;
  assign status_o = status_q;
  assign count_o  = count_q;

endmodule

// ===== sv/positional_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// ordered list of fixed-width entries kept in a row of shifting cells
// ----------------------------------------------------------------------------
// channel   direction  handshake               payload
// request   in         start high, busy low    command_i position_i item_value_i
// result    out        done_o for one cycle    status_o read_value_o length_o
//                                              empty_res_o
//
// one request per cycle; its result shows in the cycle after acceptance
// insert and remove shift each cell at or above the position in the same cycle
// get reads through a registered or-tree, groups of eight cells per branch
// reset clears count, done, status only; busy stays low, receiver cannot stall
// ----------------------------------------------------------------------------
module positional_list_engine_unit #(
  parameter int DEPTH      = 64,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [plu_pkg::CMD_W-1:0]   command_i,
  input  logic [plu_pkg::POS_W-1:0]   position_i,
  input  logic [ITEM_WIDTH-1:0]       item_value_i,
  output logic                        done_o,
  output logic [plu_pkg::STAT_W-1:0]  status_o,
  output logic [ITEM_WIDTH-1:0]       read_value_o,
  output logic [plu_pkg::POS_W-1:0]   length_o,
  output logic                        empty_res_o
);
  import plu_pkg::*;

  localparam int NumGrp = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;

  cell_ctl_t             ctl;
  logic [ITEM_WIDTH-1:0] data [DEPTH];
  logic [ITEM_WIDTH-1:0] rd   [DEPTH];
  logic [ITEM_WIDTH-1:0] grp_d [NumGrp];
  logic [ITEM_WIDTH-1:0] grp_q [NumGrp];
  logic [POS_W-1:0]      count;

  plu_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .command_i  (command_i),
    .position_i (position_i),
    .ctl_o      (ctl),
    .done_o     (done_o),
    .status_o   (status_o),
    .count_o    (count)
  );

  for (genvar c = 0; c < DEPTH; c++) begin : g_cell
    logic [ITEM_WIDTH-1:0] left, right;
    if (c == 0) begin : g_first
      assign left = item_value_i;
    end else begin : g_mid
      assign left = data[c-1];
    end
    if (c == DEPTH - 1) begin : g_last
      assign right = data[c];
    end else begin : g_inner
      assign right = data[c+1];
    end
    plu_cell #(
      .IDX        (c),
      .ITEM_WIDTH (ITEM_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .item_i  (item_value_i),
      .left_i  (left),
      .right_i (right),
      .data_o  (data[c]),
      .rd_o    (rd[c])
    );
  end

  always_comb begin
    for (int g = 0; g < NumGrp; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        if (g * GRP_SIZE + k < DEPTH) begin
          grp_d[g] = grp_d[g] | rd[g * GRP_SIZE + k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  always_comb begin
    read_value_o = '0;
    for (int g = 0; g < NumGrp; g++) begin
      read_value_o = read_value_o | grp_q[g];
    end
  end

  assign length_o    = count;
  assign empty_res_o = (count == '0);

endmodule

// ===== sv/plu_checker.sv =====
// ----------------------------------------------------------------------------
// plu_checker
// port-level checks of the positional list engine, bound to the top level
// ----------------------------------------------------------------------------
module plu_checker #(
  parameter int DEPTH      = 64,
  parameter int ITEM_WIDTH = 32
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        done_o,
  input logic [plu_pkg::STAT_W-1:0]  status_o,
  input logic [ITEM_WIDTH-1:0]       read_value_o,
  input logic [plu_pkg::POS_W-1:0]   length_o,
  input logic                        empty_res_o
);
  import plu_pkg::*;

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("accepted request gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o)
    else $error("result without a request");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (empty_res_o == (length_o == '0)))
    else $error("empty flag disagrees with length");

  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_DONE) |-> (read_value_o == '0))
    else $error("nonzero read value on a failed request");

  a_length_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (length_o <= POS_W'(DEPTH)))
    else $error("length above capacity");

endmodule

bind positional_list_engine_unit plu_checker #(
  .DEPTH      (DEPTH),
  .ITEM_WIDTH (ITEM_WIDTH)
) u_plu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .status_o     (status_o),
  .read_value_o (read_value_o),
  .length_o     (length_o),
  .empty_res_o  (empty_res_o)
);

// ===== bench/positional_list_engine_unit_test.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_unit_test
// self-checking bench for the positional list engine
// ----------------------------------------------------------------------------
// requests go in with random gaps; a behavioral copy of the list predicts
// every reply at acceptance, and a monitor compares each strobed reply field
// by field against the oldest prediction. directed tests cover empty-list
// errors, list ends, unknown commands, clear and the full list; the random
// part alternates growing and draining phases so that the list keeps
// filling up and emptying.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_list_engine_unit_test;

  import plu_pkg::*;

  localparam int LIST_DEPTH = 64;
  localparam int ITEM_W     = 32;
  localparam int RAND_ITEMS = 1000;
  localparam int PHASE_LEN  = 150;

  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ITEM_W-1:0] read_value;
    logic [POS_W-1:0]  length;
    logic              empty;
  } list_reply_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [CMD_W-1:0]  command_i;
  logic [POS_W-1:0]  position_i;
  logic [ITEM_W-1:0] item_value_i;
  logic              done_o;
  logic [STAT_W-1:0] status_o;
  logic [ITEM_W-1:0] read_value_o;
  logic [POS_W-1:0]  length_o;
  logic              empty_res_o;

  logic [ITEM_W-1:0] model_entries [LIST_DEPTH];
  int                model_count;
  list_reply_t       awaited_replies [$];
  int                error_count;

  positional_list_engine_unit #(
    .DEPTH      (LIST_DEPTH),
    .ITEM_WIDTH (ITEM_W)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (command_i),
    .position_i   (position_i),
    .item_value_i (item_value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .length_o     (length_o),
    .empty_res_o  (empty_res_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic list_reply_t list_apply(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                             logic [ITEM_W-1:0] val);
    list_reply_t r;
    int p;
    r.status     = ST_DONE;
    r.read_value = '0;
    p = int'(pos);
    case (cmd)
      CMD_INSERT: begin
        if (p < 1 || p > model_count + 1) begin
          r.status = ST_BADPOS;
        end else if (model_count >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = model_count; i >= p; i--) model_entries[i] = model_entries[i-1];
          model_entries[p-1] = val;
          model_count++;
        end
      end
      CMD_REMOVE: begin
        if (p < 1 || p > model_count) begin
          r.status = ST_BADPOS;
        end else begin
          for (int i = p - 1; i + 1 < model_count; i++) model_entries[i] = model_entries[i+1];
          model_count--;
        end
      end
      CMD_GET: begin
        if (p < 1 || p > model_count) r.status = ST_BADPOS;
        else r.read_value = model_entries[p-1];
      end
      CMD_SET: begin
        if (p < 1 || p > model_count) r.status = ST_BADPOS;
        else model_entries[p-1] = val;
      end
      CMD_CLEAR: begin
        model_count = 0;
      end
      default: begin
      end
    endcase
    r.length = model_count[POS_W-1:0];
    r.empty  = (model_count == 0);
    return r;
  endfunction

  task automatic send_request(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                              logic [ITEM_W-1:0] val);
    int gap;
    gap = $urandom_range(0, 7);
    for (int k = 0; k < gap; k++) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start        <= 1'b1;
    command_i    <= cmd;
    position_i   <= pos;
    item_value_i <= val;
    do @(posedge clk_i); while (busy !== 1'b0);
    awaited_replies.push_back(list_apply(cmd, pos, val));
  endtask

  task automatic check_field(string name, logic [ITEM_W-1:0] exp_v, logic [ITEM_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch expected %0h actual %0h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // reply monitor
  always @(posedge clk_i) begin
    list_reply_t exp_r;
    if (rst_ni && done_o === 1'b1) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected reply status %0d length %0d", $time, status_o, length_o);
        error_count++;
      end else begin
        exp_r = awaited_replies.pop_front();
        check_field("status", ITEM_W'(exp_r.status), ITEM_W'(status_o));
        check_field("read_value", exp_r.read_value, read_value_o);
        check_field("length", ITEM_W'(exp_r.length), ITEM_W'(length_o));
        check_field("empty", ITEM_W'(exp_r.empty), ITEM_W'(empty_res_o));
      end
    end
  end

  task automatic test_empty_list;
    send_request(CMD_GET, 7'd1, 32'h0);
    send_request(CMD_REMOVE, 7'd1, 32'h0);
    send_request(CMD_SET, 7'd1, 32'h1234_5678);
    send_request(CMD_INSERT, 7'd0, 32'hdead_beef);
    send_request(CMD_INSERT, 7'd2, 32'hdead_beef);
    send_request(CMD_CLEAR, 7'd0, 32'h0);
  endtask

  task automatic test_list_ends;
    send_request(CMD_INSERT, 7'd1, 32'h0000_0000);
    send_request(CMD_INSERT, 7'd1, 32'hffff_ffff);
    send_request(CMD_INSERT, 7'd3, 32'h5555_aaaa);
    send_request(CMD_GET, 7'd1, 32'h0);
    send_request(CMD_GET, 7'd3, 32'h0);
    send_request(CMD_GET, 7'd4, 32'h0);
    send_request(CMD_GET, 7'd127, 32'h0);
    send_request(CMD_SET, 7'd2, 32'haaaa_5555);
    send_request(CMD_GET, 7'd2, 32'h0);
    send_request(CMD_REMOVE, 7'd1, 32'h0);
    send_request(CMD_GET, 7'd1, 32'h0);
    send_request(CMD_REMOVE, 7'd0, 32'h0);
  endtask

  task automatic test_spare_commands;
    for (int c = int'(CMD_SPARE_FIRST); c <= int'(CMD_SPARE_LAST); c++)
      send_request(CMD_W'(c), 7'($urandom), $urandom);
    send_request(CMD_CLEAR, 7'd127, $urandom);
    send_request(CMD_GET, 7'd1, 32'h0);
  endtask

  task automatic test_full_list;
    for (int i = 0; i < LIST_DEPTH; i++)
      send_request(CMD_INSERT, 7'($urandom_range(1, i + 1)), $urandom);
    send_request(CMD_INSERT, 7'(LIST_DEPTH + 1), 32'h1);
    send_request(CMD_INSERT, 7'(LIST_DEPTH + 2), 32'h2);
    send_request(CMD_INSERT, 7'd1, 32'h3);
    send_request(CMD_GET, 7'(LIST_DEPTH), 32'h0);
    send_request(CMD_REMOVE, 7'(LIST_DEPTH), 32'h0);
    send_request(CMD_GET, 7'(LIST_DEPTH), 32'h0);
    send_request(CMD_CLEAR, 7'd0, 32'h0);
  endtask

  task automatic test_random_mix(int n_items);
    int sel;
    int pos_sel;
    int upper;
    bit grow;
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  pos;
    logic [ITEM_W-1:0] val;
    for (int n = 0; n < n_items; n++) begin
      grow = ((n / PHASE_LEN) % 2) == 0;
      sel  = $urandom_range(0, 99);
      if (grow) begin
        if (sel < 55) cmd = CMD_INSERT;
        else if (sel < 65) cmd = CMD_REMOVE;
        else if (sel < 80) cmd = CMD_GET;
        else if (sel < 94) cmd = CMD_SET;
        else if (sel < 99) cmd = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        else cmd = CMD_CLEAR;
      end else begin
        if (sel < 15) cmd = CMD_INSERT;
        else if (sel < 60) cmd = CMD_REMOVE;
        else if (sel < 77) cmd = CMD_GET;
        else if (sel < 92) cmd = CMD_SET;
        else if (sel < 96) cmd = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        else cmd = CMD_CLEAR;
      end
      upper   = (cmd == CMD_INSERT) ? model_count + 1 : model_count;
      pos_sel = $urandom_range(0, 99);
      if (pos_sel < 80 && upper > 0) pos = 7'($urandom_range(1, upper));
      else if (pos_sel < 88) pos = '0;
      else if (pos_sel < 94) pos = 7'(upper + 1);
      else pos = 7'($urandom);
      case ($urandom_range(0, 15))
        0: val = '0;
        1: val = '1;
        default: val = $urandom;
      endcase
      send_request(cmd, pos, val);
    end
  endtask

  initial begin
    start        = 1'b0;
    command_i    = '0;
    position_i   = '0;
    item_value_i = '0;
    rst_ni       = 1'b0;
    model_count  = 0;
    error_count  = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_list();
    test_list_ends();
    test_spare_commands();
    test_full_list();
    test_random_mix(RAND_ITEMS);

    @(negedge clk_i);
    start <= 1'b0;
    for (int k = 0; k < 100 && awaited_replies.size() != 0; k++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (awaited_replies.size() != 0) begin
      $display("%0t: %0d replies never arrived", $time, awaited_replies.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
